[rtl/core/i2cms_pkg.sv]
// Package for the I2C master bit sequencer: command codes, the result record
// and the sizing constants. No dependencies.
package i2cms_pkg;

  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int HALF_PERIOD_W     = 16;
  localparam int PHASE_W           = 5;
  localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd40;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_START     = 3'd1,
    OP_STOP      = 3'd2,
    OP_WRITE     = 3'd3,
    OP_READ      = 3'd4,
    OP_SEND_ACK  = 3'd5,
    OP_SEND_NACK = 3'd6,
    OP_RECV_ACK  = 3'd7
  } op_t;

  // Last boundary index of each command
  localparam logic [PHASE_W-1:0] TOTAL_START = 5'd3;
  localparam logic [PHASE_W-1:0] TOTAL_STOP  = 5'd1;
  localparam logic [PHASE_W-1:0] TOTAL_WRITE = 5'd24;
  localparam logic [PHASE_W-1:0] TOTAL_READ  = 5'd16;
  localparam logic [PHASE_W-1:0] TOTAL_OTHER = 5'd3;
  localparam logic [PHASE_W-1:0] WRITE_LAST_FALL = 5'd23;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
    logic       rejected;
  } res_t;

  function automatic logic [PHASE_W-1:0] wait_total(input op_t cmd);
    case (cmd)
      OP_START: wait_total = TOTAL_START;
      OP_STOP:  wait_total = TOTAL_STOP;
      OP_WRITE: wait_total = TOTAL_WRITE;
      OP_READ:  wait_total = TOTAL_READ;
      default:  wait_total = TOTAL_OTHER;
    endcase
  endfunction

endpackage

[rtl/core/i2cms_if.sv]
// Handshake channels of the I2C master bit sequencer: command items in,
// result items out. Depends on i2cms_pkg.
interface i2cms_in_if import i2cms_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, output op, output write_data, output sda_in, input ready);
  modport sink   (input valid, input op, input write_data, input sda_in, output ready);
endinterface

interface i2cms_out_if import i2cms_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_received;
  logic       rejected;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output read_data, output ack_received,
                  output rejected, input ready);
  modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input read_data, input ack_received,
                  input rejected, output ready);
endinterface

[rtl/core/i2cms_core.sv]
// Command sequencer state: pin levels, phase and wait counters, shift byte.
// Advances once per accepted item. Depends on i2cms_pkg.
module i2cms_core import i2cms_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [2:0]               op,
  input  logic [7:0]               write_data,
  input  logic                     sda_in,
  input  logic [HALF_PERIOD_W-1:0] half_period,
  output res_t                     res
);

  logic                   scl_level, scl_level_next;
  logic                   sda_level, sda_level_next;
  op_t                    active, active_next;
  logic [PHASE_W-1:0]     phase, phase_next;
  logic [1:0]             sub, sub_next;
  logic [COUNT_WIDTH-1:0] wait_cnt, wait_cnt_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic                   ack_bit, ack_bit_next;
  logic [7:0]             rx_hold, rx_hold_next;

  logic [31:0]            hp_wide;
  logic [COUNT_WIDTH-1:0] load_raw, load;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [PHASE_W-1:0]     nb;
  logic [1:0]             nb_sub;
  logic                   done, rej;
  op_t                    op_in;

  assign op_in    = op_t'(op);
  assign hp_wide  = {{(32-HALF_PERIOD_W){1'b0}}, half_period};
  assign load_raw = hp_wide[COUNT_WIDTH-1:0];
  assign load     = (load_raw == '0) ? COUNT_WIDTH'(1) : load_raw;
  assign cnt_dec  = (wait_cnt != '0) ? wait_cnt - COUNT_WIDTH'(1) : wait_cnt;
  assign nb       = phase + PHASE_W'(1);
  assign nb_sub   = (sub == 2'd2) ? 2'd0 : sub + 2'd1;

  always_comb begin
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    active_next     = active;
    phase_next      = phase;
    sub_next        = sub;
    wait_cnt_next   = wait_cnt;
    shift_byte_next = shift_byte;
    ack_bit_next    = ack_bit;
    rx_hold_next    = rx_hold;
    done            = 1'b0;
    rej             = 1'b0;

    if (active != OP_TICK) begin
      rej           = (op_in != OP_TICK);
      wait_cnt_next = cnt_dec;
      if (cnt_dec == '0) begin
        sub_next = nb_sub;
        case (active)
          OP_START: begin
            if (nb == 5'd1) sda_level_next = 1'b0;
            else if (nb == 5'd2) scl_level_next = 1'b0;
          end
          OP_STOP: begin
            if (nb == 5'd1) sda_level_next = 1'b1;
          end
          OP_WRITE: begin
            if (nb < TOTAL_WRITE) begin
              if (nb_sub == 2'd0) sda_level_next = shift_byte[7];
              else if (nb_sub == 2'd1) scl_level_next = 1'b1;
              else begin
                scl_level_next  = 1'b0;
                // release SDA after the last data bit
                if (nb == WRITE_LAST_FALL) sda_level_next = 1'b1;
                shift_byte_next = {shift_byte[6:0], 1'b0};
              end
            end
          end
          OP_READ: begin
            if (nb >= TOTAL_READ) rx_hold_next = shift_byte;
            else if (!nb[0]) scl_level_next = 1'b1;
            else begin
              shift_byte_next = {shift_byte[6:0], sda_in};
              scl_level_next  = 1'b0;
            end
          end
          OP_SEND_ACK: begin
            if (nb == 5'd1) scl_level_next = 1'b1;
            else if (nb == 5'd2) scl_level_next = 1'b0;
            else sda_level_next = 1'b1;
          end
          OP_SEND_NACK: begin
            if (nb == 5'd1) scl_level_next = 1'b1;
            else if (nb == 5'd2) scl_level_next = 1'b0;
          end
          OP_RECV_ACK: begin
            if (nb == 5'd1) scl_level_next = 1'b1;
            else if (nb == 5'd2) begin
              ack_bit_next   = sda_in;
              scl_level_next = 1'b0;
            end
          end
          default: ;
        endcase
        if (nb >= wait_total(active)) begin
          active_next = OP_TICK;
          phase_next  = '0;
          done        = 1'b1;
        end else begin
          phase_next    = nb;
          wait_cnt_next = load;
        end
      end
    end else if (op_in != OP_TICK) begin
      active_next   = op_in;
      phase_next    = '0;
      sub_next      = 2'd0;
      wait_cnt_next = load;
      case (op_in)
        OP_START: begin
          sda_level_next = 1'b1;
          scl_level_next = 1'b1;
        end
        OP_STOP: begin
          sda_level_next = 1'b0;
          scl_level_next = 1'b1;
        end
        OP_WRITE: begin
          shift_byte_next = write_data;
          sda_level_next  = write_data[7];
        end
        OP_READ: begin
          shift_byte_next = '0;
          sda_level_next  = 1'b1;
          scl_level_next  = 1'b1;
        end
        OP_SEND_ACK:  sda_level_next = 1'b0;
        OP_SEND_NACK: sda_level_next = 1'b1;
        OP_RECV_ACK:  sda_level_next = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      active     <= OP_TICK;
      phase      <= '0;
      sub        <= '0;
      wait_cnt   <= '0;
      shift_byte <= '0;
      ack_bit    <= 1'b0;
      rx_hold    <= '0;
    end else if (step) begin
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      active     <= active_next;
      phase      <= phase_next;
      sub        <= sub_next;
      wait_cnt   <= wait_cnt_next;
      shift_byte <= shift_byte_next;
      ack_bit    <= ack_bit_next;
      rx_hold    <= rx_hold_next;
    end
  end

  always_comb begin
    res.scl_out      = scl_level_next;
    res.sda_out      = sda_level_next;
    res.busy_res     = (active_next != OP_TICK);
    res.done_res     = done;
    res.read_data    = rx_hold_next;
    res.ack_received = ack_bit_next;
    res.rejected     = rej;
  end

endmodule

[rtl/core/i2c_master_bit_sequencer_top.sv]
// I2C master bit sequencer: one result item per command/tick item.
// Result valid in the cycle after input accept; throughput one item per cycle
// unless the output stalls; the sequencer state advances in one pass per item.
// A result register parts the channels; input is ready while it is empty or drained.
// Reset (synchronous, rst high): lines released, idle, half period 40 ticks.
module i2c_master_bit_sequencer_top import i2cms_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [HALF_PERIOD_W-1:0] cfg_wr_data,
  i2cms_in_if.sink                 in_ch,
  i2cms_out_if.source              out_ch
);

  logic [HALF_PERIOD_W-1:0] half_period;
  logic                     out_valid;
  logic                     accept;
  res_t                     res_comb, res_q;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) half_period <= HALF_PERIOD_RESET;
    else if (cfg_wr_en) half_period <= cfg_wr_data;
  end

  i2cms_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .op          (in_ch.op),
    .write_data  (in_ch.write_data),
    .sda_in      (in_ch.sda_in),
    .half_period (half_period),
    .res         (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_q <= res_comb;
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.scl_out      = res_q.scl_out;
  assign out_ch.sda_out      = res_q.sda_out;
  assign out_ch.busy_res     = res_q.busy_res;
  assign out_ch.done_res     = res_q.done_res;
  assign out_ch.read_data    = res_q.read_data;
  assign out_ch.ack_received = res_q.ack_received;
  assign out_ch.rejected     = res_q.rejected;

endmodule

[rtl/core/i2cms_checker.sv]
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// Depends on i2c_master_bit_sequencer_top and its channel signals.
module i2cms_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_busy,
  input logic out_done,
  input logic out_rejected
);

  // a finished command leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> !out_busy)
    else $error("done item reports busy");

  // an empty result register never stalls the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // every accepted item shows up as a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_done) && $stable(out_rejected))
    else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer_top i2cms_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_busy     (out_ch.busy_res),
  .out_done     (out_ch.done_res),
  .out_rejected (out_ch.rejected)
);
